// File: rtl/wrrcq_pkg.sv
// wrrcq_pkg: shared types and constants of the weighted round robin class queues
`timescale 1ns / 1ps

package wrrcq_pkg;

   localparam int NUM_CLASSES_DEF = 8;
   localparam int QUEUE_DEPTH_DEF = 16;

   localparam int ID_W    = 16;
   localparam int PRI_W   = 8;
   localparam int OCLS_W  = 4;

   typedef enum logic {
      OP_ENQUEUE = 1'b0,
      OP_DEQUEUE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      op_type                   op;
      logic [ID_W-1:0]          entry_id;
      logic signed [PRI_W-1:0]  req_priority;
      logic                     has_default;
      logic signed [PRI_W-1:0]  default_priority;
   } req_type;

   typedef struct packed {
      status_type               status;
      logic [ID_W-1:0]          out_id;
      logic [OCLS_W-1:0]        out_class;
   } rsp_type;

endpackage

// File: rtl/weighted_round_robin_class_queues.sv
// weighted_round_robin_class_queues: per-class id fifos with weighted round robin dequeue
`timescale 1ns / 1ps
//
//  channel   ports                        handshake
//  --------  ---------------------------  ------------------------------------
//  request   start, busy, req_data        beat taken when start && !busy
//  result    rsp_strobe, rsp_data         beat shown for one cycle, no stall
//
//  for each item, in the accept cycle the class is chosen and the pointers are
//  updated while the id store is written or read; the id comes through the
//  store's registered read port, the result fields are registered, and while
//  the result shows, busy is high. reset is synchronous and clears counts,
//  pointers and the turn state; the id store is not cleared and needs no pass
//  after reset. the receiver cannot stall, so results never back up.

module weighted_round_robin_class_queues
   import wrrcq_pkg::*;
#(
   parameter int NUM_CLASSES = NUM_CLASSES_DEF,
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int CLS_W  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
   localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int SRV_W  = $clog2(NUM_CLASSES + 1);
   localparam int ADDR_W = CLS_W + IDX_W;

   localparam logic signed [PRI_W-1:0] MAX_PRI  = PRI_W'(NUM_CLASSES - 1);
   localparam logic signed [PRI_W-1:0] USE_DEF  = -PRI_W'(1);
   localparam logic [IDX_W-1:0]        LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0]        FULL_CNT = CNT_W'(QUEUE_DEPTH);

   // id store: one ring per class, {class, slot} address
   logic [ID_W-1:0] store_mem [2**ADDR_W];
   logic [ID_W-1:0] rd_ff;

   // per-class ring pointers and occupancy
   logic [IDX_W-1:0] head_ff  [NUM_CLASSES];
   logic [IDX_W-1:0] tail_ff  [NUM_CLASSES];
   logic [CNT_W-1:0] count_ff [NUM_CLASSES];

   // round robin turn state
   logic [CLS_W-1:0] current_ff, current_in;
   logic [SRV_W-1:0] served_ff,  served_in;

   // result registers
   logic             strobe_ff;
   logic             pop_ff;
   status_type       status_ff, status_in;
   logic [CLS_W-1:0] class_ff,  class_in;

   logic                    accept;
   logic                    is_enq;
   logic signed [PRI_W-1:0] pri_raw;
   logic [CLS_W-1:0]        enq_cls;
   logic [NUM_CLASSES-1:0]  nonempty;
   logic                    stay;
   logic                    deq_found;
   logic [CLS_W-1:0]        deq_cls;
   logic [CLS_W-1:0]        sel_cls;
   logic [IDX_W-1:0]        head_rd, tail_rd;
   logic [CNT_W-1:0]        count_rd;
   logic                    full;
   logic                    do_push, do_pop;
   logic [IDX_W-1:0]        head_in, tail_in;
   logic [CNT_W-1:0]        push_count_in, pop_count_in;

   assign accept = start && !busy;
   assign is_enq = (req_data.op == OP_ENQUEUE);

   // priority resolution and clamp to the class range
   always_comb begin
      if (req_data.req_priority == USE_DEF && req_data.has_default) begin
         pri_raw = req_data.default_priority;
      end else begin
         pri_raw = req_data.req_priority;
      end
      if (pri_raw < 0) begin
         enq_cls = '0;
      end else if (pri_raw > MAX_PRI) begin
         enq_cls = MAX_PRI[CLS_W-1:0];
      end else begin
         enq_cls = pri_raw[CLS_W-1:0];
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
         nonempty[c] = (count_ff[c] != '0);
      end
   end

   // dequeue search: keep the current class while its turn lasts, else the
   // first nonempty class after it, wrapping back to the current class last
   always_comb begin
      logic [CLS_W:0] sum;
      stay      = ({1'b0, current_ff} >= (CLS_W+1)'(served_ff)) && nonempty[current_ff];
      deq_found = 1'b0;
      deq_cls   = current_ff;
      for (int k = NUM_CLASSES; k >= 1; k--) begin
         sum = {1'b0, current_ff} + (CLS_W+1)'(k);
         if (sum >= (CLS_W+1)'(NUM_CLASSES)) begin
            sum = sum - (CLS_W+1)'(NUM_CLASSES);
         end
         if (nonempty[sum[CLS_W-1:0]]) begin
            deq_found = 1'b1;
            deq_cls   = sum[CLS_W-1:0];
         end
      end
      if (stay) begin
         deq_found = 1'b1;
         deq_cls   = current_ff;
      end
   end

   assign sel_cls  = is_enq ? enq_cls : deq_cls;
   assign head_rd  = head_ff[sel_cls];
   assign tail_rd  = tail_ff[sel_cls];
   assign count_rd = count_ff[sel_cls];
   assign full     = (count_rd == FULL_CNT);

   assign do_push = accept && is_enq && !full;
   assign do_pop  = accept && !is_enq && deq_found;

   assign head_in       = (head_rd == LAST_IDX) ? '0 : head_rd + 1'b1;
   assign tail_in       = (tail_rd == LAST_IDX) ? '0 : tail_rd + 1'b1;
   assign push_count_in = count_rd + 1'b1;
   assign pop_count_in  = count_rd - 1'b1;

   // turn state after a dequeue; an all-empty scan comes back to the same class
   always_comb begin
      current_in = current_ff;
      served_in  = served_ff;
      if (deq_found) begin
         current_in = deq_cls;
         served_in  = stay ? served_ff + 1'b1 : SRV_W'(1);
      end else begin
         served_in  = '0;
      end
   end

   // result fields decided in the accept cycle
   always_comb begin
      status_in = ST_OK;
      class_in  = sel_cls;
      if (is_enq) begin
         if (full) begin
            status_in = ST_FULL;
         end
      end else if (!deq_found) begin
         status_in = ST_EMPTY;
         class_in  = '0;
      end
   end

   // store: write on push, registered read on pop
   always_ff @(posedge clock) begin
      if (do_push) begin
         store_mem[{sel_cls, tail_rd}] <= req_data.entry_id;
      end
      if (do_pop) begin
         rd_ff <= store_mem[{sel_cls, head_rd}];
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_CLASSES; c++) begin
            head_ff[c]  <= '0;
            tail_ff[c]  <= '0;
            count_ff[c] <= '0;
         end
         current_ff <= '0;
         served_ff  <= '0;
         strobe_ff  <= 1'b0;
         pop_ff     <= 1'b0;
      end else begin
         strobe_ff <= accept;
         if (accept) begin
            pop_ff <= do_pop;
         end
         if (do_push) begin
            tail_ff[sel_cls]  <= tail_in;
            count_ff[sel_cls] <= push_count_in;
         end
         if (do_pop) begin
            head_ff[sel_cls]  <= head_in;
            count_ff[sel_cls] <= pop_count_in;
         end
         if (accept && !is_enq) begin
            current_ff <= current_in;
            served_ff  <= served_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
         class_ff  <= class_in;
      end
   end

   assign busy               = strobe_ff;
   assign rsp_strobe         = strobe_ff;
   assign rsp_data.status    = status_ff;
   assign rsp_data.out_id    = pop_ff ? rd_ff : '0;
   assign rsp_data.out_class = OCLS_W'(class_ff);

endmodule

// File: rtl/wrrcq_checker.sv
// wrrcq_checker: port-level assertions for the class queue scheduler, with its bind
`timescale 1ns / 1ps

module wrrcq_checker
   import wrrcq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input req_type req_data,
   input logic    rsp_strobe,
   input rsp_type rsp_data
);

   // each accepted beat yields its result in the next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("accepted beat without a result");

   // no result without an accepted beat in the cycle before
   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy))
      else $error("result without an accepted beat");

   // a failed beat (empty or full) carries no id
   a_id_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.status != ST_OK |-> rsp_data.out_id == '0)
      else $error("nonzero id on a failed beat");

   // an empty dequeue names class zero and status stays within its codes
   a_empty_class: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.status != ST_EMPTY || rsp_data.out_class == '0) &&
                     (rsp_data.status == ST_OK || rsp_data.status == ST_EMPTY ||
                      rsp_data.status == ST_FULL))
      else $error("bad status or class on result");

endmodule

bind weighted_round_robin_class_queues wrrcq_checker u_wrrcq_checker (.*);
